[design/blc_pkg.sv]
package blc_pkg;

  // Default depth of the sample window
  localparam int BLC_WINDOW = 5;

  // Dividend width of the shared divider: |brake - base| (8b) times fade timer (16b)
  localparam int BLC_DVD_W = 24;

  localparam int BLC_CFG_IDX_W  = 3;
  localparam int BLC_CFG_DATA_W = 16;

  // Configuration reset values
  localparam logic signed [14:0] BLC_THR_RST     = -15'sd200;
  localparam logic signed [14:0] BLC_RELEASE_RST = -15'sd50;
  localparam logic [15:0]        BLC_HOLD_RST    = 16'd30;
  localparam logic [15:0]        BLC_RAMP_RST    = 16'd500;
  localparam logic [7:0]         BLC_DUTY_RST    = 8'd255;

  typedef enum logic [BLC_CFG_IDX_W-1:0] {
    CFG_BRAKE_THR  = 3'd0,
    CFG_RELEASE    = 3'd1,
    CFG_HOLD       = 3'd2,
    CFG_RAMP       = 3'd3,
    CFG_BRAKE_DUTY = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_BASE  = 2'd0,
    MODE_BRAKE = 2'd1,
    MODE_RAMP  = 2'd2
  } light_mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_AVG,
    ST_FADE,
    ST_OUT
  } ctrl_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic avg_start;
    logic fade_start;
    logic avg_take;
    logic fade_take;
    logic out_load;
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
    logic need_fade;
  } sts_t;

endpackage

[design/blc_div.sv]
module blc_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [blc_pkg::BLC_DVD_W-1:0] dividend,
  input  logic [15:0]                  divisor,
  output logic [blc_pkg::BLC_DVD_W-1:0] quotient,
  output logic                         rem_nz,
  output logic                         done
);

  // Restoring divider, two quotient bits per cycle
  localparam int DVD_W = blc_pkg::BLC_DVD_W;
  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [15:0]      rem_r, rem_nxt;
  logic [15:0]      dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [16:0]      trial;

  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    trial   = '0;
    for (int k = 0; k < 2; k++) begin
      trial   = {rem_nxt, quo_nxt[DVD_W-1]};
      quo_nxt = {quo_nxt[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt    = 16'(trial - {1'b0, dvs_r});
        quo_nxt[0] = 1'b1;
      end else begin
        rem_nxt = trial[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = quo_r;
  assign rem_nz   = |rem_r;
  assign done     = done_r;

endmodule

[design/blc_datapath.sv]
module blc_datapath #(
  parameter int WINDOW = blc_pkg::BLC_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  blc_pkg::cmd_t                     cmd,
  output blc_pkg::sts_t                     sts,
  input  logic signed [14:0]                in_accel_mg,
  input  logic [15:0]                       in_elapsed_ms,
  input  logic [7:0]                        in_base_level,
  input  logic                              cfg_we,
  input  logic [blc_pkg::BLC_CFG_IDX_W-1:0] cfg_index,
  input  logic [blc_pkg::BLC_CFG_DATA_W-1:0] cfg_data,
  output logic [7:0]                        out_duty,
  output logic [1:0]                        out_mode,
  output logic signed [14:0]                out_filtered_mg
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W = 16 + CNT_W;
  localparam int DVD_W = blc_pkg::BLC_DVD_W;

  function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  // Configuration registers
  logic signed [14:0] thr_r;
  logic signed [14:0] rel_r;
  logic [15:0]        hold_r;
  logic [15:0]        ramp_r;
  logic [7:0]         bduty_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= blc_pkg::BLC_THR_RST;
      rel_r   <= blc_pkg::BLC_RELEASE_RST;
      hold_r  <= blc_pkg::BLC_HOLD_RST;
      ramp_r  <= blc_pkg::BLC_RAMP_RST;
      bduty_r <= blc_pkg::BLC_DUTY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        blc_pkg::CFG_BRAKE_THR:  thr_r   <= cfg_data[14:0];
        blc_pkg::CFG_RELEASE:    rel_r   <= cfg_data[14:0];
        blc_pkg::CFG_HOLD:       hold_r  <= cfg_data;
        blc_pkg::CFG_RAMP:       ramp_r  <= cfg_data;
        blc_pkg::CFG_BRAKE_DUTY: bduty_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Sample ring with running sum; unwritten entries hold zero
  logic signed [14:0]      ring_r [WINDOW];
  logic [PTR_W-1:0]        ptr_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [15:0]             elapsed_r;
  logic [7:0]              base_r;

  assign sum_nxt = sum_r + SUM_W'(in_accel_mg) - SUM_W'(ring_r[ptr_r]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_r[i] <= '0;
      end
      ptr_r <= '0;
      cnt_r <= '0;
      sum_r <= '0;
    end else if (cmd.load) begin
      ring_r[ptr_r] <= in_accel_mg;
      ptr_r <= (ptr_r == PTR_W'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      cnt_r <= (cnt_r == CNT_W'(WINDOW)) ? cnt_r : cnt_r + 1'b1;
      sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elapsed_r <= in_elapsed_ms;
      base_r    <= in_base_level;
    end
  end

  // Threshold compares against level * count
  logic signed [SUM_W-1:0] thr_prod, rel_prod;
  logic                    below_thr, above_rel;
  logic [15:0]             below_add, fade_add;

  assign thr_prod  = SUM_W'(thr_r) * SUM_W'($signed({1'b0, cnt_r}));
  assign rel_prod  = SUM_W'(rel_r) * SUM_W'($signed({1'b0, cnt_r}));
  assign below_thr = sum_r < thr_prod;
  assign above_rel = sum_r > rel_prod;

  // Mode sequencer state and timers
  blc_pkg::light_mode_t mode_r;
  logic [15:0]          below_r;
  logic [15:0]          fade_r;
  logic                 need_fade_r;
  logic [7:0]           duty_r;
  logic signed [14:0]   avg_r;

  assign below_add = sat_add16(below_r, elapsed_r);
  assign fade_add  = sat_add16(fade_r, elapsed_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= blc_pkg::MODE_BASE;
      below_r     <= '0;
      fade_r      <= '0;
      need_fade_r <= 1'b0;
    end else if (cmd.eval) begin
      need_fade_r <= 1'b0;
      case (mode_r)
        blc_pkg::MODE_BRAKE: begin
          if (above_rel) begin
            mode_r <= blc_pkg::MODE_RAMP;
            fade_r <= '0;
          end
        end
        blc_pkg::MODE_RAMP: begin
          fade_r <= fade_add;
          if (fade_add >= ramp_r) begin
            mode_r <= blc_pkg::MODE_BASE;
          end else begin
            need_fade_r <= 1'b1;
          end
        end
        default: begin
          mode_r <= blc_pkg::MODE_BASE;
          if (below_thr) begin
            if (below_add >= hold_r) begin
              mode_r  <= blc_pkg::MODE_BRAKE;
              below_r <= '0;
            end else begin
              below_r <= below_add;
            end
          end else begin
            below_r <= '0;
          end
        end
      endcase
    end
  end

  // Shared divider: average first, then the fade step when one is needed
  logic [DVD_W-1:0] div_dvd;
  logic [15:0]      div_dvs;
  logic [DVD_W-1:0] div_quo;
  logic             div_nz;
  logic             div_done;
  logic [SUM_W-1:0] sum_mag;
  logic             fade_neg;
  logic [7:0]       fade_mag;
  logic [23:0]      fade_prod;
  logic [8:0]       fade_duty;
  logic [14:0]      avg_mag;

  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign fade_neg  = base_r > bduty_r;
  assign fade_mag  = fade_neg ? (base_r - bduty_r) : (bduty_r - base_r);
  assign fade_prod = fade_mag * fade_r;
  assign div_dvd   = cmd.fade_start ? DVD_W'(fade_prod) : DVD_W'(sum_mag);
  assign div_dvs   = cmd.fade_start ? ramp_r : 16'(cnt_r);

  blc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.avg_start | cmd.fade_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_quo),
    .rem_nz   (div_nz),
    .done     (div_done)
  );

  // floor of a negative quotient is minus the ceil of its magnitude
  assign fade_duty = fade_neg ? ({1'b0, bduty_r} + div_quo[8:0])
                              : ({1'b0, bduty_r} - div_quo[8:0] - 9'(div_nz));
  assign avg_mag   = div_quo[14:0];

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      duty_r <= (mode_r == blc_pkg::MODE_BRAKE) ? bduty_r : base_r;
    end else if (cmd.fade_take) begin
      duty_r <= fade_duty[7:0];
    end
    if (cmd.avg_take) begin
      avg_r <= sum_r[SUM_W-1] ? -avg_mag : avg_mag;
    end
    if (cmd.out_load) begin
      out_duty        <= duty_r;
      out_mode        <= mode_r;
      out_filtered_mg <= avg_r;
    end
  end

  assign sts.div_done  = div_done;
  assign sts.need_fade = need_fade_r;

endmodule

[design/blc_ctrl.sv]
module blc_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  blc_pkg::sts_t sts,
  output blc_pkg::cmd_t cmd
);

  blc_pkg::ctrl_state_t state_r, state_nxt;
  logic                 out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= blc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      blc_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = blc_pkg::ST_EVAL;
        end
      end
      blc_pkg::ST_EVAL: begin
        cmd.eval      = 1'b1;
        cmd.avg_start = 1'b1;
        state_nxt     = blc_pkg::ST_AVG;
      end
      blc_pkg::ST_AVG: begin
        if (sts.div_done) begin
          cmd.avg_take = 1'b1;
          if (sts.need_fade) begin
            cmd.fade_start = 1'b1;
            state_nxt      = blc_pkg::ST_FADE;
          end else begin
            state_nxt = blc_pkg::ST_OUT;
          end
        end
      end
      blc_pkg::ST_FADE: begin
        if (sts.div_done) begin
          cmd.fade_take = 1'b1;
          state_nxt     = blc_pkg::ST_OUT;
        end
      end
      blc_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = blc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = blc_pkg::ST_IDLE;
    endcase
  end

  assign in_stall  = (state_r != blc_pkg::ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

[design/brake_light_controller_unit.sv]
// Sequence: an accepted word passes eval and an average divide, then the
//   output register; a fade step needs a second pass through the shared
//   2-bit-per-cycle divider. Flow: the next word is taken once the result sits
//   in the output register, even while that word is stalled.
// Reset (rst_n, synchronous, active low): ring, sum, timers and mode cleared,
//   config registers back to their defaults.
module brake_light_controller_unit #(
  parameter int WINDOW = blc_pkg::BLC_WINDOW
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input samples
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [14:0]                 in_accel_mg,
  input  logic [15:0]                        in_elapsed_ms,
  input  logic [7:0]                         in_base_level,
  // results
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_duty,
  output logic [1:0]                         out_mode,
  output logic signed [14:0]                 out_filtered_mg,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [blc_pkg::BLC_CFG_IDX_W-1:0]  cfg_index,
  input  logic [blc_pkg::BLC_CFG_DATA_W-1:0] cfg_data
);

  // Controller sequences one word: load -> eval -> average divide ->
  // optional fade divide -> output register. Datapath holds the ring with a
  // running sum (old entry subtracted as the new one goes in), the mode and
  // timers, and the divider used for both sum/count and the fade step.

  blc_pkg::cmd_t cmd;
  blc_pkg::sts_t sts;

  // Config regs are always writable
  assign cfg_ready = 1'b1;

  blc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  blc_datapath #(
    .WINDOW (WINDOW)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_accel_mg     (in_accel_mg),
    .in_elapsed_ms   (in_elapsed_ms),
    .in_base_level   (in_base_level),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_duty        (out_duty),
    .out_mode        (out_mode),
    .out_filtered_mg (out_filtered_mg)
  );

endmodule
